// ===== rtl/ira_pkg.sv =====
// Shared constants, types and the digit-to-character function of the radix formatter.
package ira_pkg;

    localparam int VALUE_W       = 64;
    localparam int RADIX_W       = 5;
    localparam int DIGIT_W       = 4;
    localparam int CHAR_W        = 8;
    localparam int MAX_CHARS     = 64;
    localparam int ADDR_W        = $clog2(MAX_CHARS);
    localparam int BITS_PER_STEP = 8;
    localparam int DIV_STEPS     = VALUE_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(DIV_STEPS);

    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0]  CHAR_NONE  = 8'h00;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 4'd10;

    localparam logic STATUS_OK        = 1'b0;
    localparam logic STATUS_BAD_RADIX = 1'b1;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    // Map a digit 0..15 to '0'..'9', 'a'..'f'
    function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
        end else begin
            c = CHAR_LOW_A + {{(CHAR_W-DIGIT_W){1'b0}}, d - DIGIT_TEN};
        end
        return c;
    endfunction

endpackage

// ===== rtl/ira_divider.sv =====
// Iterative 64-bit by small-radix divider, eight quotient bits per cycle.
module ira_divider (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [ira_pkg::VALUE_W-1:0]         i_dividend,
    input  logic [ira_pkg::RADIX_W-1:0]         i_divisor,
    output ira_pkg::t_div_stat                  o_stat,
    output logic [ira_pkg::VALUE_W-1:0]         o_quotient,
    output logic [ira_pkg::DIGIT_W-1:0]         o_remainder
);

    logic [ira_pkg::VALUE_W-1:0]       r_quo, n_quo;
    logic [ira_pkg::DIGIT_W-1:0]       r_rem, n_rem;
    logic [ira_pkg::STEP_W-1:0]        r_step, n_step;
    logic                              r_busy, n_busy;
    logic                              r_done, n_done;

    logic [ira_pkg::BITS_PER_STEP-1:0] w_qbits;
    logic [ira_pkg::DIGIT_W-1:0]       w_rem;
    logic [ira_pkg::RADIX_W-1:0]       w_trial;
    logic [ira_pkg::RADIX_W-1:0]       w_diff;

    // Restoring long division on the top byte: the partial remainder stays below the divisor
    always_comb begin
        w_rem   = r_rem;
        w_qbits = '0;
        w_trial = '0;
        w_diff  = '0;
        for (int i = 0; i < ira_pkg::BITS_PER_STEP; i++) begin
            w_trial = {w_rem, r_quo[ira_pkg::VALUE_W-1-i]};
            w_diff  = w_trial - i_divisor;
            if (w_trial >= i_divisor) begin
                w_qbits[ira_pkg::BITS_PER_STEP-1-i] = 1'b1;
                w_rem = w_diff[ira_pkg::DIGIT_W-1:0];
            end else begin
                w_rem = w_trial[ira_pkg::DIGIT_W-1:0];
            end
        end
    end

    always_comb begin
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_step = r_step;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_step = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // Shift the consumed byte out, shift the quotient byte in
            n_quo  = {r_quo[ira_pkg::VALUE_W-ira_pkg::BITS_PER_STEP-1:0], w_qbits};
            n_rem  = w_rem;
            n_step = r_step + 1'b1;
            if (r_step == ira_pkg::STEP_W'(ira_pkg::DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_step <= n_step;
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_stat.busy  = r_busy;
    assign o_stat.done  = r_done;
    assign o_quotient   = r_quo;
    assign o_remainder  = r_rem;

endmodule

// ===== rtl/integer_to_radix_ascii.sv =====
// Top level: formats an unsigned 64-bit value as ASCII digits in a configurable radix.
//
// Usage:
//   Input channel s_axis: one transaction carries the 64-bit value to format.
//   Output channel m_axis: one transaction per character, most significant digit
//   first; tlast marks the final character of the number; tuser is the status
//   (0 ok, 1 invalid radix). An invalid radix (outside 2..16) gives a single
//   transaction with tdata 0, tuser 1, tlast 1. A zero value gives the single '0'.
//   Configuration: i_cfg_we writes i_cfg_wdata into the radix register (reset 10);
//   write only while the block is idle.
// Timing:
//   One item is worked on at a time; s_axis_tready is high only when idle.
//   Each digit costs one pass of the shared divider (8 byte steps plus restart),
//   and is then read back from the digit store and presented (S_RD, S_LD, S_OUT).
//   Base 2 with all 64 bits gives the worst case, 64 digits.
//   An invalid radix answers in the cycle after acceptance.
// Reset: synchronous, active low; returns to idle, radix back to 10, no output valid.
// Backpressure: a stalled receiver holds the output transaction and pauses readout.
module integer_to_radix_ascii (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ira_pkg::RADIX_W-1:0]       i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [ira_pkg::VALUE_W-1:0]       s_axis_tdata,   // [63:0] value
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [ira_pkg::CHAR_W-1:0]        m_axis_tdata,   // [7:0] out_char
    output logic                              m_axis_tuser,   // [0] status
    output logic                              m_axis_tlast
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_RD   = 5'b00100,
        S_LD   = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic [ira_pkg::RADIX_W-1:0]     r_radix, n_radix;
    logic [ira_pkg::ADDR_W-1:0]      r_wr_ptr, n_wr_ptr;
    logic [ira_pkg::ADDR_W-1:0]      r_rd_ptr, n_rd_ptr;
    logic [ira_pkg::CHAR_W-1:0]      r_out_char, n_out_char;
    logic                            r_out_status, n_out_status;
    logic                            r_out_last, n_out_last;

    // Digit store: written least significant digit first, read back in reverse
    logic [ira_pkg::DIGIT_W-1:0]     r_mem [ira_pkg::MAX_CHARS];
    logic [ira_pkg::DIGIT_W-1:0]     r_rd_data;

    logic                            w_in_accept;
    logic                            w_radix_ok;
    logic                            w_div_start;
    logic                            w_mem_we;
    logic [ira_pkg::VALUE_W-1:0]     w_div_dividend;
    ira_pkg::t_div_stat              w_div_stat;
    logic [ira_pkg::VALUE_W-1:0]     w_quotient;
    logic [ira_pkg::DIGIT_W-1:0]     w_remainder;
    logic                            w_quo_zero;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign w_radix_ok    = (r_radix >= ira_pkg::RADIX_MIN) && (r_radix <= ira_pkg::RADIX_MAX);
    assign w_quo_zero    = (w_quotient == '0);

    // First division takes the fresh value, later ones the previous quotient
    assign w_div_dividend = (r_state == S_IDLE) ? s_axis_tdata : w_quotient;

    ira_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_div_dividend),
        .i_divisor   (r_radix),
        .o_stat      (w_div_stat),
        .o_quotient  (w_quotient),
        .o_remainder (w_remainder)
    );

    always_comb begin
        n_state      = r_state;
        n_radix      = r_radix;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_out_char   = r_out_char;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        w_div_start  = 1'b0;
        w_mem_we     = 1'b0;

        if (i_cfg_we) begin
            n_radix = i_cfg_wdata;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_accept) begin
                    if (w_radix_ok) begin
                        w_div_start = 1'b1;
                        n_wr_ptr    = '0;
                        n_state     = S_DIV;
                    end else begin
                        // Single error transaction, no character
                        n_out_char   = ira_pkg::CHAR_NONE;
                        n_out_status = ira_pkg::STATUS_BAD_RADIX;
                        n_out_last   = 1'b1;
                        n_state      = S_OUT;
                    end
                end
            end
            S_DIV: begin
                if (w_div_stat.done) begin
                    w_mem_we = 1'b1;
                    n_wr_ptr = r_wr_ptr + 1'b1;
                    // Stop on a zero quotient or a full store; start readout at the top digit
                    if (w_quo_zero || (r_wr_ptr == ira_pkg::ADDR_W'(ira_pkg::MAX_CHARS - 1))) begin
                        n_rd_ptr = r_wr_ptr;
                        n_state  = S_RD;
                    end else begin
                        w_div_start = 1'b1;
                    end
                end
            end
            S_RD: begin
                // Read data lands in r_rd_data at this edge
                n_state = S_LD;
            end
            S_LD: begin
                n_out_char   = ira_pkg::to_ascii(r_rd_data);
                n_out_status = ira_pkg::STATUS_OK;
                n_out_last   = (r_rd_ptr == '0);
                n_state      = S_OUT;
            end
            S_OUT: begin
                // Hold the transaction until the receiver takes it
                if (m_axis_tready) begin
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_rd_ptr = r_rd_ptr - 1'b1;
                        n_state  = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_radix <= ira_pkg::RADIX_RESET;
        end else begin
            r_state <= n_state;
            r_radix <= n_radix;
        end
        r_wr_ptr     <= n_wr_ptr;
        r_rd_ptr     <= n_rd_ptr;
        r_out_char   <= n_out_char;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_wr_ptr] <= w_remainder;
        end
        r_rd_data <= r_mem[r_rd_ptr];
    end

    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tdata  = r_out_char;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

    // The divider is only restarted once it has finished its previous pass
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |-> !w_div_stat.busy)
        else $error("divider restarted while busy");

    // A valid-radix item sets the divider going at once
    a_accept_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_accept && w_radix_ok) |=> w_div_stat.busy)
        else $error("divider not started after accept");

    // A finished pass is always preceded by a busy cycle
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |-> $past(w_div_stat.busy))
        else $error("divider done without a pass");

    // The error transaction carries no character and closes the number
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == ira_pkg::CHAR_NONE && m_axis_tlast))
        else $error("malformed invalid-radix transaction");

    // Delivery of the final character frees the input side
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("not ready after final character");

endmodule

// ===== tb/tb.sv =====
// Testbench for the radix ASCII formatter: directed rows, then random phases against a digit predictor.
module tb;

    // Quiet cycles after the last expected char before touching the radix or ending.
    // An invalid radix answers in the cycle after acceptance and every value gives at
    // least one char, so a short margin covers the pipeline.
    localparam int DRAIN_CYCLES   = 16;
    // Cycles without any transaction before the run is declared hung. A 64-digit
    // base-2 value spends 64 divider passes before its first char, and the longest gap
    // on either side is the long branch of pick_gap.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 480;

    // One char transaction on the output side
    typedef struct packed {
        logic [ira_pkg::CHAR_W-1:0] ch;
        logic                       status;
        logic                       last;
    } t_char_beat;

    // One row of the directed stimulus; typed rows carry a single known char
    typedef struct packed {
        logic                        set_radix;
        logic [ira_pkg::RADIX_W-1:0] radix;
        logic [ira_pkg::VALUE_W-1:0] value;
        logic                        typed;
        logic [ira_pkg::CHAR_W-1:0]  exp_char;
        logic                        exp_status;
    } t_stim_row;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_cfg_we;
    logic [ira_pkg::RADIX_W-1:0] i_cfg_wdata;
    logic                        s_axis_tvalid;
    logic                        s_axis_tready;
    logic [ira_pkg::VALUE_W-1:0] s_axis_tdata;   // [63:0] value
    logic                        m_axis_tvalid;
    logic                        m_axis_tready;
    logic [ira_pkg::CHAR_W-1:0]  m_axis_tdata;   // [7:0] out_char
    logic                        m_axis_tuser;   // [0] status
    logic                        m_axis_tlast;

    t_char_beat                  pending_chars[$];   // chars still owed by the block, oldest first
    t_stim_row                   directed_rows[$];
    logic [ira_pkg::RADIX_W-1:0] radix_now;          // local copy of the radix register
    int                          error_count = 0;
    int                          idle_cycles = 0;
    int                          stall_left  = 0;
    bit                          quiet_phase = 1'b0; // no gaps on either side while set

    integer_to_radix_ascii uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Gap length in cycles: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Expected chars for one value in the given base, most significant digit first
    function automatic void predict_chars(input logic [ira_pkg::VALUE_W-1:0] value,
                                          input logic [ira_pkg::RADIX_W-1:0] base);
        logic [ira_pkg::VALUE_W-1:0] rest;
        logic [ira_pkg::VALUE_W-1:0] divisor;
        logic [ira_pkg::DIGIT_W-1:0] digit_stack[ira_pkg::MAX_CHARS];
        int                          count;
        t_char_beat                  beat;
        if (base < ira_pkg::RADIX_MIN || base > ira_pkg::RADIX_MAX) begin
            beat.ch     = ira_pkg::CHAR_NONE;
            beat.status = ira_pkg::STATUS_BAD_RADIX;
            beat.last   = 1'b1;
            pending_chars.push_back(beat);
            return;
        end
        divisor = ira_pkg::VALUE_W'(base);
        rest    = value;
        count   = 0;
        // Peel digits off the low end; a zero value still yields one digit
        do begin
            digit_stack[count] = ira_pkg::DIGIT_W'(rest % divisor);
            rest  = rest / divisor;
            count = count + 1;
        end while (rest != 0 && count < ira_pkg::MAX_CHARS);
        for (int k = count - 1; k >= 0; k--) begin
            if (digit_stack[k] < 4'd10) begin
                beat.ch = ira_pkg::CHAR_ZERO + ira_pkg::CHAR_W'(digit_stack[k]);
            end else begin
                beat.ch = ira_pkg::CHAR_LOW_A + ira_pkg::CHAR_W'(digit_stack[k] - 4'd10);
            end
            beat.status = ira_pkg::STATUS_OK;
            beat.last   = (k == 0);
            pending_chars.push_back(beat);
        end
    endfunction

    function automatic void add_row(input logic set_radix,
                                    input logic [ira_pkg::RADIX_W-1:0] radix,
                                    input logic [ira_pkg::VALUE_W-1:0] value, input logic typed,
                                    input logic [ira_pkg::CHAR_W-1:0] exp_char,
                                    input logic exp_status);
        t_stim_row row;
        row.set_radix  = set_radix;
        row.radix      = radix;
        row.value      = value;
        row.typed      = typed;
        row.exp_char   = exp_char;
        row.exp_status = exp_status;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [ira_pkg::VALUE_W-1:0] random_value();
        logic [ira_pkg::VALUE_W-1:0] full;
        full = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0, 1: return full;
            2: return full >> $urandom_range(1, 63);
            3: return ira_pkg::VALUE_W'($urandom_range(0, 40));
            // powers of two and one below them: digit rollovers in base 2, 4, 8, 16
            4: return (64'd1 << $urandom_range(0, 63)) - ira_pkg::VALUE_W'($urandom_range(0, 1));
            default: return ~64'd0 >> $urandom_range(0, 63);
        endcase
    endfunction

    // Mostly a legal base; now and then one of the out-of-range codes 0, 1, 17..31
    function automatic logic [ira_pkg::RADIX_W-1:0] random_radix();
        int pick;
        if ($urandom_range(0, 9) < 8) return ira_pkg::RADIX_W'($urandom_range(2, 16));
        pick = $urandom_range(0, 16);
        if (pick < 2) return ira_pkg::RADIX_W'(pick);
        return ira_pkg::RADIX_W'(pick + 15);
    endfunction

    task automatic report_mismatch(input string what, input logic [ira_pkg::VALUE_W-1:0] want,
                                   input logic [ira_pkg::VALUE_W-1:0] got);
        $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
        error_count++;
    endtask

    // Drop tvalid, hold until every owed char is out, then let the block settle
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Only called while the block is idle
    task automatic write_radix(input logic [ira_pkg::RADIX_W-1:0] base);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= base;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        radix_now   = base;
    endtask

    // Offer one value; on acceptance queue what it must produce
    task automatic send_value(input logic [ira_pkg::VALUE_W-1:0] value, input logic typed,
                              input logic [ira_pkg::CHAR_W-1:0] exp_char,
                              input logic exp_status);
        int         gap;
        t_char_beat beat;
        gap = quiet_phase ? 0 : pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (typed) begin
            beat.ch     = exp_char;
            beat.status = exp_status;
            beat.last   = 1'b1;
            pending_chars.push_back(beat);
        end else begin
            predict_chars(value, radix_now);
        end
    endtask

    // Receiver: ready by default, with random stalls unless the phase is quiet
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
                if (!quiet_phase) stall_left = pick_gap();
            end
        end
    end

    // Compare every output transaction against the oldest owed char
    always @(posedge i_clk) begin : check_output
        t_char_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_chars.size() == 0) begin
                report_mismatch("char with nothing owed", '0,
                                ira_pkg::VALUE_W'(m_axis_tdata));
            end else begin
                want = pending_chars.pop_front();
                if (m_axis_tdata !== want.ch)
                    report_mismatch("out_char", ira_pkg::VALUE_W'(want.ch),
                                    ira_pkg::VALUE_W'(m_axis_tdata));
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", ira_pkg::VALUE_W'(want.status),
                                    ira_pkg::VALUE_W'(m_axis_tuser));
                if (m_axis_tlast !== want.last)
                    report_mismatch("last", ira_pkg::VALUE_W'(want.last),
                                    ira_pkg::VALUE_W'(m_axis_tlast));
            end
        end
    end

    // Watchdog: restart the count on any transaction or register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int                 sent;
        int                 phase_items;
        t_stim_row          row;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        radix_now     = ira_pkg::RADIX_RESET;

        // Directed rows. The first ones run on the reset radix of ten.
        add_row(1'b0, 5'd0,  64'd0,                 1'b1, ira_pkg::CHAR_ZERO,
                ira_pkg::STATUS_OK);
        add_row(1'b0, 5'd0,  64'd7,                 1'b1, 8'h37,
                ira_pkg::STATUS_OK);
        add_row(1'b0, 5'd0,  ~64'd0,                1'b0, ira_pkg::CHAR_NONE,
                ira_pkg::STATUS_OK);
        // Base 2: the longest string, 64 ones
        add_row(1'b1, 5'd2,  ~64'd0,                1'b0, ira_pkg::CHAR_NONE,
                ira_pkg::STATUS_OK);
        add_row(1'b0, 5'd0,  64'd0,                 1'b1, ira_pkg::CHAR_ZERO,
                ira_pkg::STATUS_OK);
        add_row(1'b0, 5'd0,  64'd1,                 1'b1, 8'h31,
                ira_pkg::STATUS_OK);
        // Base 16: every letter digit and the top of the range
        add_row(1'b1, 5'd16, ~64'd0,                1'b0, ira_pkg::CHAR_NONE,
                ira_pkg::STATUS_OK);
        add_row(1'b0, 5'd0,  64'h0123456789abcdef,  1'b0, ira_pkg::CHAR_NONE,
                ira_pkg::STATUS_OK);
        add_row(1'b0, 5'd0,  64'd15,                1'b1, 8'h66,
                ira_pkg::STATUS_OK);
        add_row(1'b0, 5'd0,  64'd10,                1'b1, ira_pkg::CHAR_LOW_A,
                ira_pkg::STATUS_OK);
        // Out-of-range bases: one error transaction whatever the value
        add_row(1'b1, 5'd0,  64'd5,                 1'b1, ira_pkg::CHAR_NONE,
                ira_pkg::STATUS_BAD_RADIX);
        add_row(1'b1, 5'd1,  64'd0,                 1'b1, ira_pkg::CHAR_NONE,
                ira_pkg::STATUS_BAD_RADIX);
        add_row(1'b1, 5'd17, ~64'd0,                1'b1, ira_pkg::CHAR_NONE,
                ira_pkg::STATUS_BAD_RADIX);
        add_row(1'b1, 5'd31, 64'd123,               1'b1, ira_pkg::CHAR_NONE,
                ira_pkg::STATUS_BAD_RADIX);
        add_row(1'b1, 5'd3,  ~64'd0,                1'b0, ira_pkg::CHAR_NONE,
                ira_pkg::STATUS_OK);
        add_row(1'b1, 5'd15, 64'd14,                1'b1, 8'h65,
                ira_pkg::STATUS_OK);
        add_row(1'b1, 5'd8,  64'h8000000000000000,  1'b0, ira_pkg::CHAR_NONE,
                ira_pkg::STATUS_OK);
        add_row(1'b1, 5'd10, 64'haaaaaaaaaaaaaaaa,  1'b0, ira_pkg::CHAR_NONE,
                ira_pkg::STATUS_OK);
        add_row(1'b0, 5'd0,  64'd9999999999999999999, 1'b0, ira_pkg::CHAR_NONE,
                ira_pkg::STATUS_OK);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.set_radix) begin
                wait_idle();
                write_radix(row.radix);
            end
            send_value(row.value, row.typed, row.exp_char, row.exp_status);
        end

        // Random phases: new radix per phase, written only once the block is idle
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_idle();
            write_radix(random_radix());
            quiet_phase = ($urandom_range(0, 3) == 0);
            phase_items = $urandom_range(20, 40);
            for (int k = 0; k < phase_items && sent < RANDOM_ITEMS; k++) begin
                // occasionally hold the sender until the block has drained
                if ($urandom_range(0, 49) == 0) wait_idle();
                send_value(random_value(), 1'b0, ira_pkg::CHAR_NONE, ira_pkg::STATUS_OK);
                sent++;
            end
        end

        quiet_phase = 1'b0;
        wait_idle();
        if (error_count == 0 && pending_chars.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
